>>> design/multichannel_tanh_mixer_unit_macros.svh
// Assertion macros for the multichannel tanh mixer.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef MULTICHANNEL_TANH_MIXER_UNIT_MACROS_SVH
`define MULTICHANNEL_TANH_MIXER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MTM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mtm_pkg.sv
// Shared constants, types and the tanh breakpoint table of the mixer.
// No dependencies; imported by every mixer module.
package mtm_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int MAX_CHANNELS = 8;
    localparam int CHANNELS_DEF = 8;
    localparam int EXTRA_W      = 3;
    localparam int FRAC_BITS    = 11;
    localparam int TABLE_LAST   = 64;
    localparam int TANH_SEGMENTS = 64;
    localparam int SEG_LAST     = (TANH_SEGMENTS < TABLE_LAST) ? TANH_SEGMENTS : TABLE_LAST;
    localparam int IDX_W        = $clog2(TABLE_LAST + 1);
    localparam int DIFF_W       = 12;
    localparam int PROD_W       = DIFF_W + FRAC_BITS;

    // round(32767 * tanh(k/16)), k = 0..64
    localparam logic [SAMPLE_W-1:0] TANH_PTS [0:TABLE_LAST] = '{
        16'd0,     16'd2045,  16'd4075,  16'd6073,  16'd8025,  16'd9919,  16'd11742, 16'd13486,
        16'd15142, 16'd16706, 16'd18173, 16'd19541, 16'd20812, 16'd21986, 16'd23065, 16'd24053,
        16'd24955, 16'd25775, 16'd26518, 16'd27190, 16'd27796, 16'd28340, 16'd28829, 16'd29267,
        16'd29659, 16'd30009, 16'd30321, 16'd30599, 16'd30846, 16'd31066, 16'd31261, 16'd31435,
        16'd31588, 16'd31725, 16'd31845, 16'd31952, 16'd32047, 16'd32131, 16'd32205, 16'd32270,
        16'd32328, 16'd32380, 16'd32425, 16'd32465, 16'd32500, 16'd32531, 16'd32559, 16'd32583,
        16'd32605, 16'd32624, 16'd32641, 16'd32656, 16'd32669, 16'd32680, 16'd32690, 16'd32699,
        16'd32707, 16'd32714, 16'd32720, 16'd32726, 16'd32731, 16'd32735, 16'd32739, 16'd32742,
        16'd32745
    };

    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_tanh_ctl;

endpackage

>>> design/multichannel_tanh_mixer_unit.sv
// Multichannel tanh soft-clipping mixer, top level.
// Instantiates mtm_lane, mtm_merge and mtm_tanh; uses mtm_pkg and the assertion macros.
//
// Takes one beat of up to eight Q1.15 channel samples per clock while o_stall
// is low and gives one soft-clipped Q1.15 sample per beat. o_valid rises once
// the beat has passed four register stages: lane registers, merge adder,
// tanh table lookup, interpolation multiply. Each of the four stages advances
// whenever the stage after it is empty or moving, so the input keeps taking
// beats into any free slot while a result waits on a stalled output; o_stall
// rises only when all four stages hold data and the output is stalled.
// extra_channels selects how many channels after sample_0 enter the sum and
// takes effect on the next accepted beat; change it only while idle.
`include "multichannel_tanh_mixer_unit_macros.svh"

module multichannel_tanh_mixer_unit
    import mtm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_extra_channels_we,
    input  logic [EXTRA_W-1:0]         i_extra_channels,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_0,
    input  logic signed [SAMPLE_W-1:0] i_sample_1,
    input  logic signed [SAMPLE_W-1:0] i_sample_2,
    input  logic signed [SAMPLE_W-1:0] i_sample_3,
    input  logic signed [SAMPLE_W-1:0] i_sample_4,
    input  logic signed [SAMPLE_W-1:0] i_sample_5,
    input  logic signed [SAMPLE_W-1:0] i_sample_6,
    input  logic signed [SAMPLE_W-1:0] i_sample_7,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_mixed_sample
);

    localparam int SUM_W = SAMPLE_W + $clog2(CHANNELS);

    logic [EXTRA_W-1:0]         r_extra;
    logic [EXTRA_W-1:0]         w_extra_sat;
    logic                       r_v0, r_v1, r_v2, r_v3;
    logic                       w_en0, w_en1, w_en2, w_en3;
    logic signed [SAMPLE_W-1:0] w_samples [0:MAX_CHANNELS-1];
    logic signed [SAMPLE_W-1:0] w_terms   [0:CHANNELS-1];
    logic signed [SUM_W-1:0]    w_sum;
    t_tanh_ctl                  w_tanh_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra <= '0;
        end else if (i_extra_channels_we) begin
            r_extra <= i_extra_channels;
        end
    end

    // clamp the count to the lanes that exist
    assign w_extra_sat = (32'(r_extra) > CHANNELS - 1) ? EXTRA_W'(CHANNELS - 1) : r_extra;

    // advance a stage when the next one is empty or advancing
    assign w_en3   = !r_v3 || !i_stall;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign w_en0   = !r_v0 || w_en1;
    assign o_stall = !w_en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= i_valid;
            end
            if (w_en1) begin
                r_v1 <= r_v0;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign w_samples[0] = i_sample_0;
    assign w_samples[1] = i_sample_1;
    assign w_samples[2] = i_sample_2;
    assign w_samples[3] = i_sample_3;
    assign w_samples[4] = i_sample_4;
    assign w_samples[5] = i_sample_5;
    assign w_samples[6] = i_sample_6;
    assign w_samples[7] = i_sample_7;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        mtm_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en0),
            .i_extra  (w_extra_sat),
            .i_sample (w_samples[g]),
            .o_term   (w_terms[g])
        );
    end

    mtm_merge #(
        .CHANNELS (CHANNELS),
        .SUM_W    (SUM_W)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en1),
        .i_terms (w_terms),
        .o_sum   (w_sum)
    );

    assign w_tanh_ctl.en_a = w_en2;
    assign w_tanh_ctl.en_b = w_en3;

    mtm_tanh #(
        .SUM_W (SUM_W)
    ) u_tanh (
        .i_clk   (i_clk),
        .i_ctl   (w_tanh_ctl),
        .i_sum   (w_sum),
        .o_mixed (o_mixed_sample)
    );

    assign o_valid = r_v3;

    `MTM_ASSERT_NOW(a_stall_only_when_full, o_stall, r_v0 && r_v1 && r_v2 && r_v3 && i_stall, "input stalled with a free stage")
    `MTM_ASSERT_NEXT(a_stage_moves, r_v1 && w_en2, r_v2, "beat lost between merge and tanh")
    `MTM_ASSERT_NOW(a_out_range, o_valid, o_mixed_sample != 16'sh8000, "mixed sample out of range")

endmodule

>>> design/mtm_lane.sv
// One channel lane: gates its sample by the active channel count and registers it.
// Depends on mtm_pkg.
module mtm_lane
    import mtm_pkg::*;
#(
    parameter int LANE_IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [EXTRA_W-1:0]         i_extra,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [SAMPLE_W-1:0] o_term
);

    logic                       w_active;
    logic signed [SAMPLE_W-1:0] n_term;
    logic signed [SAMPLE_W-1:0] r_term;

    // primary lane always contributes
    assign w_active = (LANE_IDX == 0) || (32'(i_extra) >= LANE_IDX);
    assign n_term   = w_active ? i_sample : '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

>>> design/mtm_merge.sv
// Merge stage: adds the lane terms at full width and registers the sum.
// Depends on mtm_pkg.
module mtm_merge
    import mtm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int SUM_W    = SAMPLE_W + $clog2(CHANNELS)
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [SAMPLE_W-1:0] i_terms [0:CHANNELS-1],
    output logic signed [SUM_W-1:0]    o_sum
);

    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] r_sum;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            n_sum = n_sum + SUM_W'(i_terms[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> design/mtm_tanh.sv
// Two-stage piecewise-linear tanh: table lookup, then interpolate and restore sign.
// Depends on mtm_pkg for the breakpoint table and control struct.
module mtm_tanh
    import mtm_pkg::*;
#(
    parameter int SUM_W = SAMPLE_W + 3
) (
    input  logic                       i_clk,
    input  t_tanh_ctl                  i_ctl,
    input  logic signed [SUM_W-1:0]    i_sum,
    output logic signed [SAMPLE_W-1:0] o_mixed
);

    localparam int K_W = SUM_W - FRAC_BITS;

    logic [SUM_W-1:0]     w_mag;
    logic [K_W-1:0]       w_k;
    logic                 w_sat;
    logic [IDX_W-1:0]     w_idx;
    logic [IDX_W-1:0]     w_idx_hi;
    logic [SAMPLE_W-1:0]  n_base;
    logic [DIFF_W-1:0]    n_diff;

    logic [SAMPLE_W-1:0]  r_base;
    logic [DIFF_W-1:0]    r_diff;
    logic [FRAC_BITS-1:0] r_frac;
    logic                 r_neg;

    logic [PROD_W-1:0]    w_prod;
    logic [SAMPLE_W-1:0]  w_y;
    logic [SAMPLE_W-1:0]  n_out;
    logic [SAMPLE_W-1:0]  r_out;

    assign w_mag    = i_sum[SUM_W-1] ? $unsigned(-i_sum) : $unsigned(i_sum);
    assign w_k      = w_mag[SUM_W-1:FRAC_BITS];
    assign w_sat    = (32'(w_k) >= SEG_LAST);
    // past the last segment, hold the end point with a zero slope
    assign w_idx    = w_sat ? IDX_W'(SEG_LAST) : IDX_W'(w_k);
    assign w_idx_hi = w_sat ? w_idx : IDX_W'(w_idx + 1'b1);
    assign n_base   = TANH_PTS[w_idx];
    assign n_diff   = DIFF_W'(TANH_PTS[w_idx_hi] - TANH_PTS[w_idx]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_base <= n_base;
            r_diff <= n_diff;
            r_frac <= w_mag[FRAC_BITS-1:0];
            r_neg  <= i_sum[SUM_W-1];
        end
    end

    assign w_prod = PROD_W'(r_diff) * PROD_W'(r_frac);
    assign w_y    = r_base + SAMPLE_W'(w_prod >> FRAC_BITS);
    assign n_out  = r_neg ? SAMPLE_W'(-w_y) : w_y;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_b) begin
            r_out <= n_out;
        end
    end

    assign o_mixed = $signed(r_out);

endmodule
